// File: rtl/sorted_key_record_table_top_macros.svh
// Assertion macros for the sorted key record table checker
`ifndef SORTED_KEY_RECORD_TABLE_TOP_MACROS_SVH
`define SORTED_KEY_RECORD_TABLE_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low
`define SKTBL_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sorted key record table check failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low
`define SKTBL_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sorted key record table check failed");

`endif

// File: rtl/sktbl_pkg.sv
// Types, constants and codes of the sorted key record table
`default_nettype none

package sktbl_pkg;

  // Table geometry
  localparam int unsigned TABLE_DEPTH = 64;
  localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1);

  // Field widths
  localparam int unsigned KEY_W      = 32;
  localparam int unsigned NUM_SLOTS  = 4;
  localparam int unsigned VAL_W      = 8;
  localparam int unsigned CNT_IN_W   = 8;
  localparam int unsigned SCNT_W     = 2;
  localparam int unsigned ENTRIES_W  = 7;

  // Limits and reset values
  localparam logic [CNT_IN_W-1:0] SLOT_COUNT_CAP = 8'd3;
  localparam logic [VAL_W-1:0]    MAX_SLOT_RESET = 8'd165;

  typedef enum logic [1:0] {
    CMD_FIND   = 2'd0,
    CMD_UPSERT = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_RSVD   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_INVALID   = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  // Slot values in the low 32 bits, 2-bit counts above them
  typedef struct packed {
    logic [NUM_SLOTS-1:0][SCNT_W-1:0] cnt;
    logic [NUM_SLOTS-1:0][VAL_W-1:0]  val;
  } payload_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    payload_t         pay;
  } entry_t;

  // Table access request from the sequencer: write and read port fields
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

endpackage

`default_nettype wire

// File: rtl/sorted_key_record_table_top.sv
// Scan the stored keys up to the first key not below the search key, then for insert or remove
// move each entry above that point one place up or down. One command at a time; in_stall_o is
// high from acceptance until the result is loaded into the output register.
// Reset clears the fill count and sets max_slot_value to 165; table memory is not cleared,
// entries at or above the fill count are never read.
`default_nettype none

module sorted_key_record_table_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration
  input  wire logic        cfg_valid_i,
  output      logic        cfg_ready_o,
  input  wire logic [7:0]  cfg_data_i,
  // Command channel
  input  wire logic        in_valid_i,
  output      logic        in_stall_o,
  input  wire logic [1:0]  command_i,
  input  wire logic [31:0] record_key_i,
  input  wire logic [7:0]  slot_value_0_i,
  input  wire logic [7:0]  slot_value_1_i,
  input  wire logic [7:0]  slot_value_2_i,
  input  wire logic [7:0]  slot_value_3_i,
  input  wire logic [7:0]  slot_count_0_i,
  input  wire logic [7:0]  slot_count_1_i,
  input  wire logic [7:0]  slot_count_2_i,
  input  wire logic [7:0]  slot_count_3_i,
  // Result channel
  output      logic        out_valid_o,
  input  wire logic        out_stall_i,
  output      logic [1:0]  status_o,
  output      logic [6:0]  entries_in_use_o,
  output      logic [7:0]  found_value_0_o,
  output      logic [7:0]  found_value_1_o,
  output      logic [7:0]  found_value_2_o,
  output      logic [7:0]  found_value_3_o,
  output      logic [1:0]  found_count_0_o,
  output      logic [1:0]  found_count_1_o,
  output      logic [1:0]  found_count_2_o,
  output      logic [1:0]  found_count_3_o
);

  logic [sktbl_pkg::VAL_W-1:0]                              max_val_q;
  logic [sktbl_pkg::NUM_SLOTS-1:0][sktbl_pkg::VAL_W-1:0]    vals;
  logic [sktbl_pkg::NUM_SLOTS-1:0][sktbl_pkg::CNT_IN_W-1:0] cnts;
  logic                                                     rec_ok;
  sktbl_pkg::payload_t                                      rec_pay;
  sktbl_pkg::status_e                                       status;
  sktbl_pkg::payload_t                                      found;
  sktbl_pkg::mem_req_t                                      mem_req;
  sktbl_pkg::entry_t                                        mem_rdata;

  // Configuration register, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_val_q <= sktbl_pkg::MAX_SLOT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_val_q <= cfg_data_i;
    end
  end

  assign vals = {slot_value_3_i, slot_value_2_i, slot_value_1_i, slot_value_0_i};
  assign cnts = {slot_count_3_i, slot_count_2_i, slot_count_1_i, slot_count_0_i};

  sktbl_check u_check (
    .key_i     (record_key_i),
    .vals_i    (vals),
    .cnts_i    (cnts),
    .max_val_i (max_val_q),
    .ok_o      (rec_ok),
    .pay_o     (rec_pay)
  );

  sktbl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .command_i   (command_i),
    .key_i       (record_key_i),
    .pay_i       (rec_pay),
    .rec_ok_i    (rec_ok),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status),
    .entries_o   (entries_in_use_o),
    .found_o     (found),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  sktbl_ram #(
    .DATA_W ($bits(sktbl_pkg::entry_t)),
    .DEPTH  (sktbl_pkg::TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .re_i    (mem_req.re),
    .raddr_i (mem_req.raddr),
    .rdata_o (mem_rdata)
  );

  // Unpack the result beat
  assign status_o        = status;
  assign found_value_0_o = found.val[0];
  assign found_value_1_o = found.val[1];
  assign found_value_2_o = found.val[2];
  assign found_value_3_o = found.val[3];
  assign found_count_0_o = found.cnt[0];
  assign found_count_1_o = found.cnt[1];
  assign found_count_2_o = found.cnt[2];
  assign found_count_3_o = found.cnt[3];

endmodule

`default_nettype wire

// File: rtl/sktbl_ram.sv
// Simple dual-port table memory with registered read data
`default_nettype none

module sktbl_ram #(
  parameter int unsigned DATA_W = 72,
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [DATA_W-1:0] wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output      logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, data registered and valid in the cycle after the address
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: rtl/sktbl_check.sv
// Record validation and payload packing for upsert
`default_nettype none

module sktbl_check (
  input  wire logic [sktbl_pkg::KEY_W-1:0]                              key_i,
  input  wire logic [sktbl_pkg::NUM_SLOTS-1:0][sktbl_pkg::VAL_W-1:0]    vals_i,
  input  wire logic [sktbl_pkg::NUM_SLOTS-1:0][sktbl_pkg::CNT_IN_W-1:0] cnts_i,
  input  wire logic [sktbl_pkg::VAL_W-1:0]                              max_val_i,
  output      logic                                                     ok_o,
  output      sktbl_pkg::payload_t                                      pay_o
);

  logic empty_seen;

  // Walk the slots: nonzero key, packed to the front, in range, empty slots carry no count
  always_comb begin
    empty_seen = 1'b0;
    ok_o       = (key_i != '0);
    for (int k = 0; k < sktbl_pkg::NUM_SLOTS; k++) begin
      if (vals_i[k] == '0) begin
        empty_seen = 1'b1;
        if (cnts_i[k] != '0) begin
          ok_o = 1'b0;
        end
      end else begin
        if (empty_seen) begin
          ok_o = 1'b0;
        end
        if (vals_i[k] > max_val_i) begin
          ok_o = 1'b0;
        end
        if (cnts_i[k] > sktbl_pkg::SLOT_COUNT_CAP) begin
          ok_o = 1'b0;
        end
      end
    end
  end

  // Pack values and the low bits of the counts
  always_comb begin
    for (int k = 0; k < sktbl_pkg::NUM_SLOTS; k++) begin
      pay_o.val[k] = vals_i[k];
      pay_o.cnt[k] = cnts_i[k][sktbl_pkg::SCNT_W-1:0];
    end
  end

endmodule

`default_nettype wire

// File: rtl/sktbl_ctrl.sv
// Sequencer: key scan through the shared comparator, shift walks, result register
`default_nettype none

module sktbl_ctrl (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // Command beat
  input  wire logic                           in_valid_i,
  output      logic                           in_stall_o,
  input  wire logic [1:0]                     command_i,
  input  wire logic [sktbl_pkg::KEY_W-1:0]    key_i,
  input  wire sktbl_pkg::payload_t            pay_i,
  input  wire logic                           rec_ok_i,
  // Result beat
  output      logic                           out_valid_o,
  input  wire logic                           out_stall_i,
  output      sktbl_pkg::status_e             status_o,
  output      logic [sktbl_pkg::ENTRIES_W-1:0] entries_o,
  output      sktbl_pkg::payload_t            found_o,
  // Table memory
  output      sktbl_pkg::mem_req_t            mem_req_o,
  input  wire sktbl_pkg::entry_t              mem_rdata_i
);

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_SCAN     = 6'b000010,
    S_SHIFT_UP = 6'b000100,
    S_SHIFT_DN = 6'b001000,
    S_WRITE    = 6'b010000,
    S_FINISH   = 6'b100000
  } state_e;

  localparam int unsigned IDX_W = sktbl_pkg::IDX_W;
  localparam int unsigned CNT_W = sktbl_pkg::CNT_W;

  state_e                        state_q, state_d;
  sktbl_pkg::cmd_e               cmd_q, cmd_d;
  logic [sktbl_pkg::KEY_W-1:0]   key_q, key_d;
  sktbl_pkg::payload_t           pay_q, pay_d;
  logic [CNT_W-1:0]              used_q, used_d;
  logic [CNT_W-1:0]              iss_q, iss_d;
  logic                          rv_q, rv_d;
  logic [IDX_W-1:0]              ridx_q, ridx_d;
  logic [CNT_W-1:0]              pos_q, pos_d;
  logic                          hit_q, hit_d;
  logic [CNT_W-1:0]              rem_q, rem_d;
  logic [IDX_W-1:0]              addr_q, addr_d;
  sktbl_pkg::status_e            st_q, st_d;
  sktbl_pkg::payload_t           fpay_q, fpay_d;
  logic                          out_valid_q, out_valid_d;
  sktbl_pkg::status_e            out_status_q, out_status_d;
  logic [sktbl_pkg::ENTRIES_W-1:0] out_entries_q, out_entries_d;
  sktbl_pkg::payload_t           out_found_q, out_found_d;

  // Shared key comparator
  logic             cmp_eq, cmp_gt;
  logic             stop, stop_hit;
  logic [CNT_W-1:0] pos_sel;

  assign cmp_eq = (mem_rdata_i.key == key_q);
  assign cmp_gt = (mem_rdata_i.key > key_q);

  // Scan ends at the first stored key not below the search key, or past the end
  always_comb begin
    stop     = 1'b0;
    stop_hit = 1'b0;
    pos_sel  = used_q;
    if (rv_q && (cmp_eq || cmp_gt)) begin
      stop     = 1'b1;
      stop_hit = cmp_eq;
      pos_sel  = CNT_W'(ridx_q);
    end else if (!rv_q && (iss_q >= used_q)) begin
      stop = 1'b1;
    end
  end

  // Next state and memory requests
  always_comb begin
    state_d       = state_q;
    cmd_d         = cmd_q;
    key_d         = key_q;
    pay_d         = pay_q;
    used_d        = used_q;
    iss_d         = iss_q;
    rv_d          = rv_q;
    ridx_d        = ridx_q;
    pos_d         = pos_q;
    hit_d         = hit_q;
    rem_d         = rem_q;
    addr_d        = addr_q;
    st_d          = st_q;
    fpay_d        = fpay_q;
    out_valid_d   = out_valid_q && out_stall_i;
    out_status_d  = out_status_q;
    out_entries_d = out_entries_q;
    out_found_d   = out_found_q;
    mem_req_o     = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d  = sktbl_pkg::cmd_e'(command_i);
          key_d  = key_i;
          pay_d  = pay_i;
          iss_d  = '0;
          rv_d   = 1'b0;
          hit_d  = 1'b0;
          fpay_d = '0;
          st_d   = sktbl_pkg::ST_OK;
          unique case (sktbl_pkg::cmd_e'(command_i))
            sktbl_pkg::CMD_FIND,
            sktbl_pkg::CMD_REMOVE: begin
              state_d = S_SCAN;
            end
            sktbl_pkg::CMD_UPSERT: begin
              if (rec_ok_i) begin
                state_d = S_SCAN;
              end else begin
                st_d    = sktbl_pkg::ST_INVALID;
                state_d = S_FINISH;
              end
            end
            default: begin
              st_d    = sktbl_pkg::ST_INVALID;
              state_d = S_FINISH;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (stop) begin
          rv_d  = 1'b0;
          pos_d = pos_sel;
          hit_d = stop_hit;
          unique case (cmd_q)
            sktbl_pkg::CMD_FIND: begin
              if (stop_hit) begin
                fpay_d = mem_rdata_i.pay;
              end else begin
                st_d = sktbl_pkg::ST_NOT_FOUND;
              end
              state_d = S_FINISH;
            end
            sktbl_pkg::CMD_UPSERT: begin
              if (stop_hit) begin
                state_d = S_WRITE;
              end else if (used_q == CNT_W'(sktbl_pkg::TABLE_DEPTH)) begin
                st_d    = sktbl_pkg::ST_FULL;
                state_d = S_FINISH;
              end else begin
                rem_d   = used_q - pos_sel;
                addr_d  = IDX_W'(used_q - CNT_W'(1));
                state_d = S_SHIFT_UP;
              end
            end
            sktbl_pkg::CMD_REMOVE: begin
              if (stop_hit) begin
                rem_d   = used_q - pos_sel - CNT_W'(1);
                addr_d  = IDX_W'(pos_sel + CNT_W'(1));
                state_d = S_SHIFT_DN;
              end else begin
                st_d    = sktbl_pkg::ST_NOT_FOUND;
                state_d = S_FINISH;
              end
            end
            default: begin
              st_d    = sktbl_pkg::ST_INVALID;
              state_d = S_FINISH;
            end
          endcase
        end else if (iss_q < used_q) begin
          // Issue the next key read
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = iss_q[IDX_W-1:0];
          iss_d           = iss_q + CNT_W'(1);
          rv_d            = 1'b1;
          ridx_d          = iss_q[IDX_W-1:0];
        end else begin
          rv_d = 1'b0;
        end
      end

      S_SHIFT_UP: begin
        // Move each entry from the top down to the insert point one place up
        if (rv_q) begin
          mem_req_o.we    = 1'b1;
          mem_req_o.waddr = ridx_q + IDX_W'(1);
          mem_req_o.wdata = mem_rdata_i;
        end
        if (rem_q != '0) begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = addr_q;
          addr_d          = addr_q - IDX_W'(1);
          rem_d           = rem_q - CNT_W'(1);
          rv_d            = 1'b1;
          ridx_d          = addr_q;
        end else begin
          rv_d = 1'b0;
          if (!rv_q) begin
            state_d = S_WRITE;
          end
        end
      end

      S_SHIFT_DN: begin
        // Move each entry above the removed one one place down
        if (rv_q) begin
          mem_req_o.we    = 1'b1;
          mem_req_o.waddr = ridx_q - IDX_W'(1);
          mem_req_o.wdata = mem_rdata_i;
        end
        if (rem_q != '0) begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = addr_q;
          addr_d          = addr_q + IDX_W'(1);
          rem_d           = rem_q - CNT_W'(1);
          rv_d            = 1'b1;
          ridx_d          = addr_q;
        end else begin
          rv_d = 1'b0;
          if (!rv_q) begin
            used_d  = used_q - CNT_W'(1);
            state_d = S_FINISH;
          end
        end
      end

      S_WRITE: begin
        // Store the new record, replacing or filling the opened slot
        mem_req_o.we        = 1'b1;
        mem_req_o.waddr     = pos_q[IDX_W-1:0];
        mem_req_o.wdata.key = key_q;
        mem_req_o.wdata.pay = pay_q;
        if (!hit_q) begin
          used_d = used_q + CNT_W'(1);
        end
        state_d = S_FINISH;
      end

      S_FINISH: begin
        // Load the result once the output register is free
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d   = 1'b1;
          out_status_d  = st_q;
          out_entries_d = sktbl_pkg::ENTRIES_W'(used_q);
          out_found_d   = fpay_q;
          state_d       = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      used_q      <= '0;
      rv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      rv_q        <= rv_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working and result payload
  always_ff @(posedge clk_i) begin
    cmd_q         <= cmd_d;
    key_q         <= key_d;
    pay_q         <= pay_d;
    iss_q         <= iss_d;
    ridx_q        <= ridx_d;
    pos_q         <= pos_d;
    hit_q         <= hit_d;
    rem_q         <= rem_d;
    addr_q        <= addr_d;
    st_q          <= st_d;
    fpay_q        <= fpay_d;
    out_status_q  <= out_status_d;
    out_entries_q <= out_entries_d;
    out_found_q   <= out_found_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign entries_o   = out_entries_q;
  assign found_o     = out_found_q;

endmodule

`default_nettype wire

// File: rtl/sktbl_checker.sv
// Port-level checker for the sorted key record table, bound to the top level
`default_nettype none
`include "sorted_key_record_table_top_macros.svh"

module sktbl_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [1:0]  status_o,
  input wire logic [6:0]  entries_in_use_o,
  input wire logic [7:0]  found_value_0_o,
  input wire logic [7:0]  found_value_1_o,
  input wire logic [7:0]  found_value_2_o,
  input wire logic [7:0]  found_value_3_o,
  input wire logic [1:0]  found_count_0_o,
  input wire logic [1:0]  found_count_1_o,
  input wire logic [1:0]  found_count_2_o,
  input wire logic [1:0]  found_count_3_o
);

  logic       out_wait;
  logic       rsp_fail;
  logic       found_any;
  logic [8:0] rsp_head;

  assign out_wait  = out_valid_o && out_stall_i;
  assign rsp_fail  = out_valid_o && (status_o != sktbl_pkg::ST_OK);
  assign found_any = |{found_value_3_o, found_value_2_o, found_value_1_o, found_value_0_o,
                       found_count_3_o, found_count_2_o, found_count_1_o, found_count_0_o};
  assign rsp_head  = {status_o, entries_in_use_o};

  // Hold a stalled result beat: valid, status and entry count stay
  `SKTBL_ASSERT_NXT(a_out_hold, out_wait, out_valid_o && $stable(rsp_head))

  // Go busy after taking a command
  `SKTBL_ASSERT_NXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)

  // Never report more entries than the table holds
  `SKTBL_ASSERT_IMP(a_fill_bound, out_valid_o, int'(entries_in_use_o) <= sktbl_pkg::TABLE_DEPTH)

  // Found fields are zero on every response whose status is not OK
  `SKTBL_ASSERT_IMP(a_found_zero, rsp_fail, !found_any)

endmodule

bind sorted_key_record_table_top sktbl_checker u_checker (.*);

`default_nettype wire

// File: dv/tb_sorted_key_record_table_top.sv
// Self-checking testbench for the sorted key record table: find, upsert and remove traffic
`timescale 1ns / 100ps

module tb_sorted_key_record_table_top;

  localparam int POOL_N          = 96;
  localparam int HOLD_AT_BEAT    = 500;
  localparam int HOLD_CYCLES     = 300;
  localparam int DRAIN_CYCLES    = 150;
  localparam int WATCHDOG_CYCLES = 3000;

  typedef struct packed {
    sktbl_pkg::cmd_e                                          cmd;
    logic [sktbl_pkg::KEY_W-1:0]                              key;
    logic [sktbl_pkg::NUM_SLOTS-1:0][sktbl_pkg::VAL_W-1:0]    val;
    logic [sktbl_pkg::NUM_SLOTS-1:0][sktbl_pkg::CNT_IN_W-1:0] cnt;
  } table_cmd_t;

  typedef struct packed {
    sktbl_pkg::status_e                                     status;
    logic [sktbl_pkg::ENTRIES_W-1:0]                        entries;
    logic [sktbl_pkg::NUM_SLOTS-1:0][sktbl_pkg::VAL_W-1:0]  val;
    logic [sktbl_pkg::NUM_SLOTS-1:0][sktbl_pkg::SCNT_W-1:0] cnt;
  } table_rsp_t;

  // Shadow copy of the table plus the queue of responses it predicts
  class table_scoreboard;
    logic [sktbl_pkg::KEY_W-1:0] keys [sktbl_pkg::TABLE_DEPTH];
    sktbl_pkg::payload_t         pays [sktbl_pkg::TABLE_DEPTH];
    int                          used;
    logic [sktbl_pkg::VAL_W-1:0] max_val;
    table_rsp_t                  rsp_q[$];
    int unsigned                 mismatches;
    int unsigned                 checked;
    int unsigned                 status_hits [4];
    int                          peak_used;

    function new();
      for (int i = 0; i < sktbl_pkg::TABLE_DEPTH; i++) begin
        keys[i] = '0;
        pays[i] = '0;
      end
      used       = 0;
      max_val    = sktbl_pkg::MAX_SLOT_RESET;
      mismatches = 0;
      checked    = 0;
      peak_used  = 0;
      for (int s = 0; s < 4; s++) status_hits[s] = 0;
    endfunction

    function int pending();
      return rsp_q.size();
    endfunction

    function void report(string msg);
      mismatches++;
      if (mismatches <= 10) $display("[%0t] MISMATCH beat %0d: %s", $time, checked, msg);
    endfunction

    // Nonzero key, packed slots, no slot after an empty one, values and counts in range, no count on an empty slot
    function bit record_ok(table_cmd_t c);
      bit hole = 1'b0;
      if (c.key == '0) return 1'b0;
      for (int k = 0; k < sktbl_pkg::NUM_SLOTS; k++) begin
        if (c.val[k] == '0) begin
          hole = 1'b1;
          if (c.cnt[k] != '0) return 1'b0;
        end else begin
          if (hole) return 1'b0;
          if (c.val[k] > max_val) return 1'b0;
          if (c.cnt[k] > sktbl_pkg::SLOT_COUNT_CAP) return 1'b0;
        end
      end
      return 1'b1;
    endfunction

    function int find_pos(logic [sktbl_pkg::KEY_W-1:0] key);
      if (key == '0) return -1;
      for (int i = 0; i < used; i++)
        if (keys[i] == key) return i;
      return -1;
    endfunction

    // Apply one accepted command to the shadow table and queue its response
    function void note_command(table_cmd_t c);
      table_rsp_t          r;
      sktbl_pkg::payload_t p;
      int                  pos;
      int                  at;
      r = '0;
      r.status = sktbl_pkg::ST_OK;
      for (int k = 0; k < sktbl_pkg::NUM_SLOTS; k++) begin
        p.val[k] = c.val[k];
        p.cnt[k] = c.cnt[k][sktbl_pkg::SCNT_W-1:0];
      end
      case (c.cmd)
        sktbl_pkg::CMD_FIND: begin
          pos = find_pos(c.key);
          if (pos < 0) begin
            r.status = sktbl_pkg::ST_NOT_FOUND;
          end else begin
            r.val = pays[pos].val;
            r.cnt = pays[pos].cnt;
          end
        end
        sktbl_pkg::CMD_UPSERT: begin
          pos = find_pos(c.key);
          if (!record_ok(c)) begin
            r.status = sktbl_pkg::ST_INVALID;
          end else if (pos >= 0) begin
            pays[pos] = p;
          end else if (used >= sktbl_pkg::TABLE_DEPTH) begin
            r.status = sktbl_pkg::ST_FULL;
          end else begin
            // shift larger keys up and drop the new record into the gap
            at = used;
            while (at > 0 && keys[at-1] > c.key) begin
              keys[at] = keys[at-1];
              pays[at] = pays[at-1];
              at--;
            end
            keys[at] = c.key;
            pays[at] = p;
            used++;
          end
        end
        sktbl_pkg::CMD_REMOVE: begin
          pos = find_pos(c.key);
          if (pos < 0) begin
            r.status = sktbl_pkg::ST_NOT_FOUND;
          end else begin
            // close the gap and clear the freed last entry
            for (int i = pos; i + 1 < used; i++) begin
              keys[i] = keys[i+1];
              pays[i] = pays[i+1];
            end
            keys[used-1] = '0;
            pays[used-1] = '0;
            used--;
          end
        end
        default: r.status = sktbl_pkg::ST_INVALID;
      endcase
      r.entries = used[sktbl_pkg::ENTRIES_W-1:0];
      if (used > peak_used) peak_used = used;
      status_hits[int'(r.status)]++;
      rsp_q.push_back(r);
    endfunction

    // Compare one response beat against the oldest prediction
    function void check_result(table_rsp_t got);
      table_rsp_t want;
      checked++;
      if (rsp_q.size() == 0) begin
        report($sformatf("response with nothing outstanding (status %0d)", got.status));
        return;
      end
      want = rsp_q.pop_front();
      if (got.status !== want.status)
        report($sformatf("status expected %0d got %0d", want.status, got.status));
      if (got.entries !== want.entries)
        report($sformatf("entries_in_use expected %0d got %0d", want.entries, got.entries));
      for (int k = 0; k < sktbl_pkg::NUM_SLOTS; k++) begin
        if (got.val[k] !== want.val[k])
          report($sformatf("found_value_%0d expected %0d got %0d", k, want.val[k], got.val[k]));
        if (got.cnt[k] !== want.cnt[k])
          report($sformatf("found_count_%0d expected %0d got %0d", k, want.cnt[k], got.cnt[k]));
      end
    endfunction
  endclass

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                        cfg_valid = 1'b0;
  logic [sktbl_pkg::VAL_W-1:0] cfg_data  = '0;
  logic                        cfg_ready;

  logic       in_valid  = 1'b0;
  table_cmd_t in_beat   = '0;
  logic       in_stall;
  logic       out_valid;
  logic       out_stall = 1'b0;

  logic [1:0] status_o;
  logic [6:0] entries_in_use_o;
  logic [7:0] found_value_0_o, found_value_1_o, found_value_2_o, found_value_3_o;
  logic [1:0] found_count_0_o, found_count_1_o, found_count_2_o, found_count_3_o;
  table_rsp_t dut_rsp;

  table_scoreboard             sb;
  logic [sktbl_pkg::KEY_W-1:0] key_pool [POOL_N];
  bit                          quiet = 1'b0;
  int unsigned                 idle_cycles = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  sorted_key_record_table_top u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .command_i        (in_beat.cmd),
    .record_key_i     (in_beat.key),
    .slot_value_0_i   (in_beat.val[0]),
    .slot_value_1_i   (in_beat.val[1]),
    .slot_value_2_i   (in_beat.val[2]),
    .slot_value_3_i   (in_beat.val[3]),
    .slot_count_0_i   (in_beat.cnt[0]),
    .slot_count_1_i   (in_beat.cnt[1]),
    .slot_count_2_i   (in_beat.cnt[2]),
    .slot_count_3_i   (in_beat.cnt[3]),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .status_o         (status_o),
    .entries_in_use_o (entries_in_use_o),
    .found_value_0_o  (found_value_0_o),
    .found_value_1_o  (found_value_1_o),
    .found_value_2_o  (found_value_2_o),
    .found_value_3_o  (found_value_3_o),
    .found_count_0_o  (found_count_0_o),
    .found_count_1_o  (found_count_1_o),
    .found_count_2_o  (found_count_2_o),
    .found_count_3_o  (found_count_3_o)
  );

  assign dut_rsp = {status_o, entries_in_use_o,
                    found_value_3_o, found_value_2_o, found_value_1_o, found_value_0_o,
                    found_count_3_o, found_count_2_o, found_count_1_o, found_count_0_o};

  // Wait drawn per beat; none while a quiet stretch is running
  function automatic int draw_wait();
    return quiet ? 0 : $urandom_range(0, 15);
  endfunction

  function automatic table_cmd_t mk_cmd(sktbl_pkg::cmd_e c, logic [31:0] key,
                                        logic [31:0] vals, logic [31:0] cnts);
    table_cmd_t t;
    t.cmd = c;
    t.key = key;
    t.val = vals;
    t.cnt = cnts;
    return t;
  endfunction

  // Mostly well-formed records on pool keys, about one in five given altered slot fields
  function automatic table_cmd_t random_cmd(int upsert_pct, int remove_pct);
    table_cmd_t t;
    int         roll;
    int         n;
    int         k;
    roll = $urandom_range(0, 99);
    if (roll < upsert_pct)                   t.cmd = sktbl_pkg::CMD_UPSERT;
    else if (roll < upsert_pct + remove_pct) t.cmd = sktbl_pkg::CMD_REMOVE;
    else if (roll < 97)                      t.cmd = sktbl_pkg::CMD_FIND;
    else                                     t.cmd = sktbl_pkg::CMD_RSVD;
    roll = $urandom_range(0, 19);
    if (roll == 0)      t.key = '0;
    else if (roll == 1) t.key = $urandom;
    else                t.key = key_pool[$urandom_range(0, POOL_N - 1)];
    n = (sb.max_val == '0) ? 0 : $urandom_range(0, sktbl_pkg::NUM_SLOTS);
    for (k = 0; k < sktbl_pkg::NUM_SLOTS; k++) begin
      t.val[k] = (k < n) ? sktbl_pkg::VAL_W'($urandom_range(1, sb.max_val)) : '0;
      t.cnt[k] = (k < n) ? sktbl_pkg::CNT_IN_W'($urandom_range(0, 3)) : '0;
    end
    if ($urandom_range(0, 4) == 0) begin
      k = $urandom_range(0, sktbl_pkg::NUM_SLOTS - 1);
      case ($urandom_range(0, 4))
        0:       t.val[k] = '0;
        1:       t.val[k] = sktbl_pkg::VAL_W'($urandom_range(sb.max_val, 255));
        2:       t.cnt[k] = sktbl_pkg::CNT_IN_W'($urandom_range(4, 255));
        3:       t.cnt[k] = sktbl_pkg::CNT_IN_W'($urandom_range(1, 3));
        default: begin
          t.val = $urandom;
          t.cnt = $urandom;
        end
      endcase
    end
    return t;
  endfunction

  // Offer one command beat and hold it until the block takes it
  task automatic send_cmd(table_cmd_t c);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_beat  <= c;
    do @(posedge clk_i); while (in_stall);
    sb.note_command(c);
  endtask

  // Stop offering and let every outstanding response come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [sktbl_pkg::VAL_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.max_val = v;
  endtask

  task automatic run_phase(int count, int upsert_pct, int remove_pct);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 39) == 0) quiet = !quiet;
      send_cmd(random_cmd(upsert_pct, remove_pct));
    end
  endtask

  // Check every response beat that the sink takes
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) sb.check_result(dut_rsp);
  end

  // Abort when no channel has moved a beat for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_CYCLES) begin
        $display("[%0t] watchdog: no beat for %0d cycles", $time, WATCHDOG_CYCLES);
        $display("tb_sorted_key_record_table_top failed");
        $finish;
      end
    end
  end

  // Response sink: random stall per beat, one long hold to back the block up
  initial begin : result_sink
    int beats;
    int hold;
    beats = 0;
    @(posedge rst_ni);
    forever begin
      hold = (beats == HOLD_AT_BEAT) ? HOLD_CYCLES : draw_wait();
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk_i);
        out_stall <= 1'b0;
      end
      do @(posedge clk_i); while (!out_valid);
      beats++;
    end
  end

  initial begin : stimulus
    sb = new();
    key_pool[0] = 32'h0000_0001;
    key_pool[1] = 32'hFFFF_FFFF;
    key_pool[2] = 32'h8000_0000;
    key_pool[3] = 32'h7FFF_FFFF;
    for (int i = 4; i < POOL_N; i++) begin
      key_pool[i] = $urandom;
      if (key_pool[i] == '0) key_pool[i] = 32'h0000_0002;
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty table, key zero, each invalid record form, ends and middle
    send_cmd(mk_cmd(sktbl_pkg::CMD_FIND,   32'h0000_0001, 32'h0, 32'h0));
    send_cmd(mk_cmd(sktbl_pkg::CMD_FIND,   32'h0000_0000, 32'h0, 32'h0));
    send_cmd(mk_cmd(sktbl_pkg::CMD_REMOVE, 32'h0000_0000, 32'h0, 32'h0));
    send_cmd(mk_cmd(sktbl_pkg::CMD_REMOVE, 32'h0000_0005, 32'h0, 32'h0));
    send_cmd(mk_cmd(sktbl_pkg::CMD_UPSERT, 32'h0000_0000, 32'h0000_0005, 32'h0000_0001));
    send_cmd(mk_cmd(sktbl_pkg::CMD_UPSERT, 32'h0000_0001, 32'h0014_000A, 32'h0));
    send_cmd(mk_cmd(sktbl_pkg::CMD_UPSERT, 32'h0000_0001, 32'h0000_00A6, 32'h0));
    send_cmd(mk_cmd(sktbl_pkg::CMD_UPSERT, 32'hFFFF_FFFF, 32'hA5A5_A5A5, 32'h0303_0303));
    send_cmd(mk_cmd(sktbl_pkg::CMD_UPSERT, 32'h0000_0001, 32'h0000_0001, 32'h0000_0004));
    send_cmd(mk_cmd(sktbl_pkg::CMD_UPSERT, 32'h0000_0001, 32'h0000_0001, 32'h0001_0000));
    send_cmd(mk_cmd(sktbl_pkg::CMD_UPSERT, 32'h0000_0001, 32'h0000_0000, 32'h0000_0000));
    send_cmd(mk_cmd(sktbl_pkg::CMD_UPSERT, 32'h8000_0000, 32'h0003_0201, 32'h0002_0100));
    send_cmd(mk_cmd(sktbl_pkg::CMD_UPSERT, 32'h8000_0000, 32'h0000_0007, 32'h0000_0003));
    send_cmd(mk_cmd(sktbl_pkg::CMD_FIND,   32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_cmd(mk_cmd(sktbl_pkg::CMD_FIND,   32'hFFFF_FFFF, 32'h0, 32'h0));
    send_cmd(mk_cmd(sktbl_pkg::CMD_FIND,   32'h0000_0001, 32'h0, 32'h0));
    send_cmd(mk_cmd(sktbl_pkg::CMD_RSVD,   32'h8000_0000, 32'h0000_0001, 32'h0));
    send_cmd(mk_cmd(sktbl_pkg::CMD_REMOVE, 32'h8000_0000, 32'h0, 32'h0));
    send_cmd(mk_cmd(sktbl_pkg::CMD_FIND,   32'h8000_0000, 32'h0, 32'h0));
    send_cmd(mk_cmd(sktbl_pkg::CMD_REMOVE, 32'h0000_0001, 32'h0, 32'h0));
    send_cmd(mk_cmd(sktbl_pkg::CMD_REMOVE, 32'hFFFF_FFFF, 32'h0, 32'h0));
    send_cmd(mk_cmd(sktbl_pkg::CMD_FIND,   32'hFFFF_FFFF, 32'h0, 32'h0));

    // Random phases: fill to full, drain with no slot allowed, then mixed limits
    wait_drained();
    write_limit(8'd255);
    run_phase(300, 70, 5);
    wait_drained();
    write_limit(8'd0);
    run_phase(200, 20, 50);
    wait_drained();
    write_limit(sktbl_pkg::VAL_W'($urandom_range(1, 254)));
    run_phase(300, 45, 30);
    wait_drained();
    write_limit(8'd1);
    run_phase(200, 60, 15);
    wait_drained();
    write_limit(sktbl_pkg::MAX_SLOT_RESET);
    run_phase(330, 50, 25);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Checked %0d responses; ok %0d, not found %0d, invalid %0d, full %0d",
             sb.checked, sb.status_hits[sktbl_pkg::ST_OK],
             sb.status_hits[sktbl_pkg::ST_NOT_FOUND],
             sb.status_hits[sktbl_pkg::ST_INVALID], sb.status_hits[sktbl_pkg::ST_FULL]);
    $display("Peak fill %0d of %0d entries, slot limits 165, 255, 0, mid and 1; %0d mismatches",
             sb.peak_used, sktbl_pkg::TABLE_DEPTH, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("tb_sorted_key_record_table_top passed");
    end else begin
      $display("tb_sorted_key_record_table_top failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/sktbl_pkg.sv
rtl/sktbl_ram.sv
rtl/sktbl_check.sv
rtl/sktbl_ctrl.sv
rtl/sorted_key_record_table_top.sv
rtl/sktbl_checker.sv
dv/tb_sorted_key_record_table_top.sv
